[sv/stq_pkg.sv]
// Shared types and constants for the sorted timer queue.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package stq_pkg;

  // Sizing
  localparam int TIMER_SLOTS = 16;
  localparam int NUM_IDS     = 16;
  localparam int CAP         = (TIMER_SLOTS < NUM_IDS) ? TIMER_SLOTS : NUM_IDS;
  localparam int IDX_W       = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W       = $clog2(CAP + 1);

  // Field widths
  localparam int ID_W     = 4;
  localparam int TIME_W   = 63;
  localparam int RELOAD_W = 16;
  localparam int KIND_W   = 2;

  // Reload clamp bounds
  localparam logic [RELOAD_W-1:0] RELOAD_MIN = 16'd2;
  localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'd65535;

  // Input operation codes
  localparam logic OP_ARM = 1'b0;
  localparam logic OP_IRQ = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FIRE   = 2'd0,
    KIND_RELOAD = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM_CHECK,
    ST_ARM_SCAN,
    ST_FIRE,
    ST_RELOAD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  load;       // capture the input word
    logic  arm_shift;  // move entry j-1 up to j, step j down
    logic  arm_place;  // write the new timer at j
    logic  pop;        // drop the head entry
    logic  emit;       // load the output register
    kind_t emit_kind;
    logic  emit_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_irq;
    logic id_pending;
    logic full;
    logic scan_move;
    logic j_zero;
    logic head_due;
    logic has_pending;
    logic one_pending;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[sv/stq_in_if.sv]
// Input channel of the timer queue: valid/ready plus the request word.
// Depends on stq_pkg for field widths.
`default_nettype none

interface stq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [stq_pkg::ID_W-1:0]   timer_id;
  logic [stq_pkg::TIME_W-1:0] expire_time;
  logic [stq_pkg::TIME_W-1:0] now;

  modport source (output valid, output op, output timer_id, output expire_time,
                  output now, input ready);
  modport sink   (input valid, input op, input timer_id, input expire_time,
                  input now, output ready);
endinterface

`default_nettype wire

[sv/stq_out_if.sv]
// Result channel of the timer queue: valid/ready plus the result word.
// Depends on stq_pkg for field widths.
`default_nettype none

interface stq_out_if;
  logic                        valid;
  logic                        ready;
  logic [stq_pkg::KIND_W-1:0]   kind;
  logic [stq_pkg::ID_W-1:0]     fired_id;
  logic [stq_pkg::TIME_W-1:0]   fired_time;
  logic [stq_pkg::RELOAD_W-1:0] reload_value;
  logic                        last;

  modport source (output valid, output kind, output fired_id, output fired_time,
                  output reload_value, output last, input ready);
  modport sink   (input valid, input kind, input fired_id, input fired_time,
                  input reload_value, input last, output ready);
endinterface

`default_nettype wire

[sv/sorted_timer_queue.sv]
// Top level of the sorted timer queue: controller plus datapath.
// Depends on stq_pkg, stq_in_if, stq_out_if, stq_ctrl and stq_datapath.
//
//   channel | dir | word carried
//   in_ch   | in  | op, timer_id, expire_time, now
//   out_ch  | out | kind, fired_id, fired_time, reload_value, last
//
// One request at a time. A stored arm walks down from the table tail past
// each entry later than the new expiry and is placed, with a reload word
// if it lands at the head; a rejected arm sends one reject word.
// An interrupt fires each due timer, then a reload word if any remain.
// A held result stalls the sequencer until out_ch takes it.
// Synchronous active-low reset clears the fill count, flags and valids; the
// table contents need no clearing.
`default_nettype none

module sorted_timer_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  stq_pkg::cmd_t  cmd;
  stq_pkg::stat_t stat;

  // Sequencer
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table and result word
  stq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_ch.op),
    .in_timer_id      (in_ch.timer_id),
    .in_expire_time   (in_ch.expire_time),
    .in_now           (in_ch.now),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_fired_id     (out_ch.fired_id),
    .out_fired_time   (out_ch.fired_time),
    .out_reload_value (out_ch.reload_value),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

[sv/stq_ctrl.sv]
// Sequencing controller for the timer queue.
// Depends on stq_pkg (state_t, cmd_t, stat_t); drives the datapath by commands.
`default_nettype none

module stq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire stq_pkg::stat_t stat,
  output      stq_pkg::cmd_t  cmd
);

  stq_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stq_pkg::ST_ARM_CHECK;
        end
      end
      stq_pkg::ST_ARM_CHECK: begin
        if (stat.op_irq) begin
          state_nxt = stq_pkg::ST_FIRE;
        end else if (stat.id_pending || stat.full) begin
          if (stat.out_free) begin
            state_nxt = stq_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = stq_pkg::ST_ARM_SCAN;
        end
      end
      stq_pkg::ST_ARM_SCAN: begin
        if (!stat.scan_move) begin
          state_nxt = stat.j_zero ? stq_pkg::ST_RELOAD : stq_pkg::ST_IDLE;
        end
      end
      stq_pkg::ST_FIRE: begin
        if (!stat.head_due) begin
          state_nxt = stat.has_pending ? stq_pkg::ST_RELOAD : stq_pkg::ST_IDLE;
        end
      end
      stq_pkg::ST_RELOAD: begin
        if (stat.out_free) begin
          state_nxt = stq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.arm_shift = 1'b0;
    cmd.arm_place = 1'b0;
    cmd.pop       = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_kind = stq_pkg::KIND_FIRE;
    cmd.emit_last = 1'b0;
    case (state_r)
      stq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      stq_pkg::ST_ARM_CHECK: begin
        // rejected arm: one word, nothing stored
        if (!stat.op_irq && (stat.id_pending || stat.full)) begin
          cmd.emit      = stat.out_free;
          cmd.emit_kind = stq_pkg::KIND_REJECT;
          cmd.emit_last = 1'b1;
        end
      end
      stq_pkg::ST_ARM_SCAN: begin
        cmd.arm_shift = stat.scan_move;
        cmd.arm_place = !stat.scan_move;
      end
      stq_pkg::ST_FIRE: begin
        // fire the head; final word when no timer remains behind it
        if (stat.head_due && stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = stq_pkg::KIND_FIRE;
          cmd.emit_last = stat.one_pending;
          cmd.pop       = 1'b1;
        end
      end
      stq_pkg::ST_RELOAD: begin
        cmd.emit      = stat.out_free;
        cmd.emit_kind = stq_pkg::KIND_RELOAD;
        cmd.emit_last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/stq_datapath.sv]
// Timer table, pending flags, input capture and output register.
// Depends on stq_pkg; acts on commands from stq_ctrl and reports status.
`default_nettype none

module stq_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_op,
  input  wire logic [stq_pkg::ID_W-1:0]     in_timer_id,
  input  wire logic [stq_pkg::TIME_W-1:0]   in_expire_time,
  input  wire logic [stq_pkg::TIME_W-1:0]   in_now,
  input  wire stq_pkg::cmd_t                cmd,
  output      stq_pkg::stat_t               stat,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [stq_pkg::KIND_W-1:0]   out_kind,
  output      logic [stq_pkg::ID_W-1:0]     out_fired_id,
  output      logic [stq_pkg::TIME_W-1:0]   out_fired_time,
  output      logic [stq_pkg::RELOAD_W-1:0] out_reload_value,
  output      logic                         out_last
);

  localparam int CAP   = stq_pkg::CAP;
  localparam int IDX_W = stq_pkg::IDX_W;
  localparam int CNT_W = stq_pkg::CNT_W;

  // Sorted table, earliest first
  logic [stq_pkg::TIME_W-1:0] exp_tab_r [CAP];
  logic [stq_pkg::ID_W-1:0]   own_tab_r [CAP];

  logic                       op_r;
  logic [stq_pkg::ID_W-1:0]   id_r;
  logic [stq_pkg::TIME_W-1:0] exp_r;
  logic [stq_pkg::TIME_W-1:0] now_r;
  logic [IDX_W-1:0]           j_r;
  logic [CNT_W-1:0]           count_r;
  logic [stq_pkg::NUM_IDS-1:0] flags_r;

  logic                         out_valid_r;
  logic [stq_pkg::KIND_W-1:0]   kind_r;
  logic [stq_pkg::ID_W-1:0]     fid_r;
  logic [stq_pkg::TIME_W-1:0]   ftime_r;
  logic [stq_pkg::RELOAD_W-1:0] reload_r;
  logic                         last_r;

  logic [IDX_W-1:0]           jm1;
  logic [stq_pkg::TIME_W-1:0] rd_exp;
  logic [stq_pkg::ID_W-1:0]   rd_own;
  logic [stq_pkg::TIME_W:0]   diff;
  logic [stq_pkg::RELOAD_W-1:0] reload_val;

  // Entry just below the insertion point
  assign jm1    = j_r - 1'b1;
  assign rd_exp = exp_tab_r[jm1];
  assign rd_own = own_tab_r[jm1];

  // Reload from head expiry, clamped to the counter range
  assign diff = {1'b0, exp_tab_r[0]} - {1'b0, now_r};
  always_comb begin
    if (exp_tab_r[0] <= now_r) begin
      reload_val = stq_pkg::RELOAD_MIN;
    end else if (diff[stq_pkg::TIME_W:stq_pkg::RELOAD_W] != '0) begin
      reload_val = stq_pkg::RELOAD_MAX;
    end else if (diff[stq_pkg::RELOAD_W-1:0] < stq_pkg::RELOAD_MIN) begin
      reload_val = stq_pkg::RELOAD_MIN;
    end else begin
      reload_val = diff[stq_pkg::RELOAD_W-1:0];
    end
  end

  // Status
  always_comb begin
    stat.op_irq      = (op_r == stq_pkg::OP_IRQ);
    stat.id_pending  = flags_r[id_r];
    stat.full        = (count_r >= CNT_W'(CAP));
    stat.scan_move   = (j_r != '0) && (rd_exp > exp_r);
    stat.j_zero      = (j_r == '0);
    stat.has_pending = (count_r != '0);
    stat.one_pending = (count_r == CNT_W'(1));
    stat.head_due    = (count_r != '0) && (exp_tab_r[0] <= now_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      id_r  <= in_timer_id;
      exp_r <= in_expire_time;
      now_r <= in_now;
    end
  end

  // Insertion index walks down from the tail
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      j_r <= count_r[IDX_W-1:0];
    end else if (cmd.arm_shift) begin
      j_r <= jm1;
    end
  end

  // Table entries: shift up on insert, shift down on pop
  for (genvar i = 0; i < CAP; i++) begin : g_slot
    if (i < CAP - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.arm_shift && (j_r == IDX_W'(i))) begin
          exp_tab_r[i] <= rd_exp;
          own_tab_r[i] <= rd_own;
        end else if (cmd.arm_place && (j_r == IDX_W'(i))) begin
          exp_tab_r[i] <= exp_r;
          own_tab_r[i] <= id_r;
        end else if (cmd.pop) begin
          exp_tab_r[i] <= exp_tab_r[i+1];
          own_tab_r[i] <= own_tab_r[i+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.arm_shift && (j_r == IDX_W'(i))) begin
          exp_tab_r[i] <= rd_exp;
          own_tab_r[i] <= rd_own;
        end else if (cmd.arm_place && (j_r == IDX_W'(i))) begin
          exp_tab_r[i] <= exp_r;
          own_tab_r[i] <= id_r;
        end
      end
    end
  end

  // Fill count and per-id pending flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flags_r <= '0;
    end else if (cmd.arm_place) begin
      count_r       <= count_r + 1'b1;
      flags_r[id_r] <= 1'b1;
    end else if (cmd.pop) begin
      count_r               <= count_r - 1'b1;
      flags_r[own_tab_r[0]] <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r <= cmd.emit_kind;
      last_r <= cmd.emit_last;
      case (cmd.emit_kind)
        stq_pkg::KIND_FIRE: begin
          fid_r    <= own_tab_r[0];
          ftime_r  <= exp_tab_r[0];
          reload_r <= '0;
        end
        stq_pkg::KIND_RELOAD: begin
          fid_r    <= '0;
          ftime_r  <= '0;
          reload_r <= reload_val;
        end
        stq_pkg::KIND_REJECT: begin
          fid_r    <= id_r;
          ftime_r  <= '0;
          reload_r <= '0;
        end
        default: begin
          fid_r    <= '0;
          ftime_r  <= '0;
          reload_r <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_fired_id     = fid_r;
  assign out_fired_time   = ftime_r;
  assign out_reload_value = reload_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire
